/* rtl/rctl_pkg.sv */
// ----------------------------------------------------------------------------
// Register change trace log: shared types and constants
// Command and result beat layouts, log record layout, operation codes and
// configuration register indexes.
// ----------------------------------------------------------------------------
package rctl_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_TIME_VALID_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WATCH_BASE     = 2'd1;

  localparam logic [31:0] TIME_VALID_RESET = 32'd1700000000;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_READ   = 1'b1;

  typedef struct packed {
    logic        op;
    logic [3:0]  reg_index;
    logic [7:0]  reg_value;
    logic [31:0] sample_time;
    logic        sweep_end;
    logic [4:0]  read_pos;
  } cmd_t;

  typedef struct packed {
    logic        hit;
    logic [7:0]  rec_addr;
    logic [7:0]  rec_before;
    logic [7:0]  rec_after;
    logic [31:0] rec_time;
    logic [5:0]  rec_count;
  } result_t;

  typedef struct packed {
    logic [7:0]  addr;
    logic [7:0]  prior;
    logic [7:0]  after;
    logic [31:0] stamp;
  } rec_t;

endpackage

/* rtl/rctl_shadow.sv */
// ----------------------------------------------------------------------------
// Last-value store
// Holds the most recent value of each watched register. Entries read as zero
// until written after reset. The read is registered and forwards a write to
// the same entry in the same cycle.
// ----------------------------------------------------------------------------
module rctl_shadow #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0]       mem [DEPTH];
  logic [DEPTH-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else if (vld[rd_addr]) begin
        rd_data <= mem[rd_addr];
      end else begin
        rd_data <= '0;
      end
    end
  end

endmodule

/* rtl/rctl_ring.sv */
// ----------------------------------------------------------------------------
// Trace ring memory
// One write port and one registered read port. A write to the entry being
// read in the same cycle is forwarded to the read data.
// ----------------------------------------------------------------------------
module rctl_ring #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  logic           clk,
  input  logic           wr_en,
  input  logic [AW-1:0]  wr_addr,
  input  rctl_pkg::rec_t wr_data,
  input  logic           rd_en,
  input  logic [AW-1:0]  rd_addr,
  output rctl_pkg::rec_t rd_data
);

  rctl_pkg::rec_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

/* rtl/register_change_trace_log.sv */
// ----------------------------------------------------------------------------
// Register change trace log
// Watches a bank of byte registers through sample beats and logs every
// change after the priming sweep into a ring that keeps the newest records.
// ----------------------------------------------------------------------------
//
// Channel    Ports                           Direction  Transfer
// ---------  ------------------------------  ---------  ---------------------
// command    start, busy, cmd                in         start && !busy
// result     done, result                    out        done (one cycle)
// config     wr_en, wr_index, wr_data        in         wr_en
//
// A command beat is taken in every cycle in which busy is low. The accepting
// edge loads the command register and the memory reads, the next edge loads
// the result register, so done is high in the cycle after that edge and the
// result is taken at the edge that ends it. Throughput is one beat per cycle
// while busy is low, set by the single-pass compare and ring write in the
// second stage. Reset is synchronous and clears the last-value store (through
// per-entry valid bits), the ring write pointer, the fill count and the
// priming flag; busy is high while reset is asserted. The receiver cannot
// stall, so there is no output back-pressure and done is a pure strobe.
//
module register_change_trace_log #(
  parameter int unsigned WATCHED_REGS = 16,
  parameter int unsigned LOG_DEPTH    = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  rctl_pkg::cmd_t                    cmd,
  output logic                              done,
  output rctl_pkg::result_t                 result,
  input  logic                              wr_en,
  input  logic [rctl_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [rctl_pkg::CFG_DATA_W-1:0]   wr_data
);

  localparam int unsigned IDX_W  = (WATCHED_REGS > 1) ? $clog2(WATCHED_REGS) : 1;
  localparam int unsigned PTR_W  = $clog2(LOG_DEPTH);
  localparam int unsigned FILL_W = $clog2(LOG_DEPTH + 1);
  localparam int unsigned SUM_W  = ((PTR_W > 5) ? PTR_W : 5) + 1;

  // Configuration registers.
  logic [31:0] time_valid_min;
  logic [7:0]  watch_base;

  // Control state.
  logic              primed;
  logic [PTR_W-1:0]  write_ptr;
  logic [FILL_W-1:0] log_fill;
  logic              s1_valid;
  rctl_pkg::cmd_t    s1_cmd;

  // Stage-one results and next-state values.
  logic              primed_next;
  logic [PTR_W-1:0]  write_ptr_next;
  logic [FILL_W-1:0] log_fill_next;
  logic              s1_sample;
  logic              s1_in_rng;
  logic [IDX_W-1:0]  s1_idx;
  logic              s1_change;
  logic              s1_read_hit;
  logic              sh_we;
  logic [7:0]        sh_rd;
  rctl_pkg::rec_t    rec_new;
  rctl_pkg::rec_t    ring_rd;

  // Stage-zero read addressing.
  logic              fire;
  logic              in_rng;
  logic              sh_re;
  logic              ring_re;
  logic [PTR_W-1:0]  start_slot;
  logic [SUM_W-1:0]  slot_sum;
  logic [SUM_W-1:0]  slot_wrap;
  logic [PTR_W-1:0]  ring_raddr;

  assign busy = rst;
  assign fire = start && !busy;

  // Configuration writes. Unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      time_valid_min <= rctl_pkg::TIME_VALID_RESET;
      watch_base     <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        rctl_pkg::CFG_TIME_VALID_MIN: time_valid_min <= wr_data[31:0];
        rctl_pkg::CFG_WATCH_BASE:     watch_base     <= wr_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // Stage one: compare against the stored value and decide the record.
  always_comb begin
    s1_sample = (s1_cmd.op == rctl_pkg::OP_SAMPLE);
    s1_in_rng = (9'(s1_cmd.reg_index) < 9'(WATCHED_REGS));
    s1_idx    = IDX_W'(s1_cmd.reg_index);
    s1_change = s1_valid && s1_sample && primed && s1_in_rng &&
                (s1_cmd.reg_value != sh_rd);
    sh_we     = s1_valid && s1_sample && s1_in_rng && (!primed || s1_change);
    primed_next = primed || (s1_valid && s1_sample && s1_cmd.sweep_end);

    rec_new.addr   = watch_base + 8'(s1_cmd.reg_index);
    rec_new.prior  = sh_rd;
    rec_new.after  = s1_cmd.reg_value;
    rec_new.stamp  = (s1_cmd.sample_time > time_valid_min) ? s1_cmd.sample_time : '0;

    write_ptr_next = write_ptr;
    log_fill_next  = log_fill;
    if (s1_change) begin
      write_ptr_next = (write_ptr == PTR_W'(LOG_DEPTH - 1)) ? '0 : write_ptr + 1'b1;
      if (log_fill != FILL_W'(LOG_DEPTH)) begin
        log_fill_next = log_fill + 1'b1;
      end
    end

    s1_read_hit = s1_valid && !s1_sample &&
                  (SUM_W'(s1_cmd.read_pos) < SUM_W'(log_fill));
  end

  // Stage zero: the ring slot is computed from the pointers as they will be
  // once the item ahead has finished, so back-to-back reads see its record.
  always_comb begin
    in_rng     = (9'(cmd.reg_index) < 9'(WATCHED_REGS));
    sh_re      = fire && (cmd.op == rctl_pkg::OP_SAMPLE) && in_rng;
    start_slot = (log_fill_next == FILL_W'(LOG_DEPTH)) ? write_ptr_next : '0;
    slot_sum   = SUM_W'(start_slot) + SUM_W'(cmd.read_pos);
    slot_wrap  = (slot_sum >= SUM_W'(LOG_DEPTH)) ? slot_sum - SUM_W'(LOG_DEPTH) : slot_sum;
    ring_raddr = slot_wrap[PTR_W-1:0];
    ring_re    = fire && (cmd.op == rctl_pkg::OP_READ) &&
                 (SUM_W'(cmd.read_pos) < SUM_W'(log_fill_next));
  end

  rctl_shadow #(
    .DEPTH (WATCHED_REGS),
    .AW    (IDX_W)
  ) u_shadow (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (sh_we),
    .wr_addr (s1_idx),
    .wr_data (s1_cmd.reg_value),
    .rd_en   (sh_re),
    .rd_addr (IDX_W'(cmd.reg_index)),
    .rd_data (sh_rd)
  );

  rctl_ring #(
    .DEPTH (LOG_DEPTH),
    .AW    (PTR_W)
  ) u_ring (
    .clk     (clk),
    .wr_en   (s1_change),
    .wr_addr (write_ptr),
    .wr_data (rec_new),
    .rd_en   (ring_re),
    .rd_addr (ring_raddr),
    .rd_data (ring_rd)
  );

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      primed    <= 1'b0;
      write_ptr <= '0;
      log_fill  <= '0;
      s1_valid  <= 1'b0;
      done      <= 1'b0;
    end else begin
      primed    <= primed_next;
      write_ptr <= write_ptr_next;
      log_fill  <= log_fill_next;
      s1_valid  <= fire;
      done      <= s1_valid;
    end
  end

  // Command register and result register.
  always_ff @(posedge clk) begin
    if (fire) begin
      s1_cmd <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      result.rec_count <= 6'(log_fill_next);
      if (s1_change) begin
        result.hit        <= 1'b1;
        result.rec_addr   <= rec_new.addr;
        result.rec_before <= rec_new.prior;
        result.rec_after  <= rec_new.after;
        result.rec_time   <= rec_new.stamp;
      end else if (s1_read_hit) begin
        result.hit        <= 1'b1;
        result.rec_addr   <= ring_rd.addr;
        result.rec_before <= ring_rd.prior;
        result.rec_after  <= ring_rd.after;
        result.rec_time   <= ring_rd.stamp;
      end else begin
        result.hit        <= 1'b0;
        result.rec_addr   <= '0;
        result.rec_before <= '0;
        result.rec_after  <= '0;
        result.rec_time   <= '0;
      end
    end
  end

endmodule
